### hw/rtl/rvs_pkg.sv
// ----------------------------------------------------------------------------
// Record varint serializer package
// Shared types, byte constants and varint helpers for the record serializer.
// ----------------------------------------------------------------------------
package rvs_pkg;

	// Byte-level constants of the encoding.
	localparam logic [7:0] TOP_KEY_BYTE = 8'h0A;  // field 1, length-delimited
	localparam logic [2:0] WIRE_VARINT  = 3'd0;
	localparam int unsigned NUM_FIELDS  = 6;
	localparam int unsigned GROUP_BITS  = 7;
	localparam int unsigned MAX_GROUPS  = 10;

	// Width of the entry length (at most 26 bytes).
	localparam int unsigned LEN_W = 5;
	// Width of the field index (0 to 5).
	localparam int unsigned FLD_W = 3;
	localparam logic [FLD_W-1:0] LAST_FIELD = FLD_W'(NUM_FIELDS - 1);

	// One input record.
	typedef struct packed {
		logic [15:0] rnti;
		logic [63:0] time_us;
		logic [11:0] ta_value;
		logic [7:0]  source;
		logic        attached;
		logic [9:0]  ue_idx;
	} rec_t;

	// One encoded output byte.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} enc_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_LEN,
		ST_KEY,
		ST_VAL
	} state_t;

	// Byte source selected by the controller.
	typedef enum logic [1:0] {
		SEL_HDR,
		SEL_LEN,
		SEL_KEY,
		SEL_VAL
	} sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic emit;
		sel_t sel;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic val_last;
		logic field_last;
	} status_t;

	// Number of varint bytes needed for a value: one per 7-bit group up to
	// the highest nonzero group, and at least one.
	function automatic logic [3:0] varint_bytes(input logic [63:0] v);
		logic [3:0] n;
		n = 4'd1;
		for (int g = 1; g < MAX_GROUPS; g++) begin
			if ((v >> (GROUP_BITS * g)) != 64'd0) begin
				n = 4'(g + 1);
			end
		end
		return n;
	endfunction

endpackage

### hw/rtl/rvs_ctrl.sv
// ----------------------------------------------------------------------------
// Record serializer controller
// Sequences header, length, and key/value bytes of each record.
// ----------------------------------------------------------------------------
module rvs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rec_valid,
	output logic             rec_stall,
	input  rvs_pkg::status_t status,
	output rvs_pkg::cmd_t    cmd
);
	import rvs_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic; each non-idle state moves on when a byte is emitted, ST_VAL only on a value's last byte.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (rec_valid) begin
					state_d = ST_HDR;
				end
			end
			ST_HDR: begin
				if (status.out_free) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				if (status.out_free) begin
					state_d = ST_KEY;
				end
			end
			ST_KEY: begin
				if (status.out_free) begin
					state_d = ST_VAL;
				end
			end
			ST_VAL: begin
				if (status.out_free && status.val_last) begin
					state_d = status.field_last ? ST_IDLE : ST_KEY;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output logic.
	always_comb begin
		rec_stall = 1'b1;
		cmd.load  = 1'b0;
		cmd.emit  = 1'b0;
		cmd.sel   = SEL_HDR;
		unique case (state_q)
			ST_IDLE: begin
				rec_stall = 1'b0;
				cmd.load  = rec_valid;
			end
			ST_HDR: begin
				cmd.emit = status.out_free;
				cmd.sel  = SEL_HDR;
			end
			ST_LEN: begin
				cmd.emit = status.out_free;
				cmd.sel  = SEL_LEN;
			end
			ST_KEY: begin
				cmd.emit = status.out_free;
				cmd.sel  = SEL_KEY;
			end
			ST_VAL: begin
				cmd.emit = status.out_free;
				cmd.sel  = SEL_VAL;
			end
			default: begin
				rec_stall = 1'b1;
			end
		endcase
	end

endmodule

### hw/rtl/rvs_datapath.sv
// ----------------------------------------------------------------------------
// Record serializer datapath
// Holds the record, the entry length, the varint shifter and the output byte.
// ----------------------------------------------------------------------------
module rvs_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  rvs_pkg::rec_t    rec,
	input  logic             enc_stall,
	output logic             enc_valid,
	output rvs_pkg::enc_t    enc,
	input  rvs_pkg::cmd_t    cmd,
	output rvs_pkg::status_t status
);
	import rvs_pkg::*;

	rec_t             rec_q;
	logic [LEN_W-1:0] len_q;
	logic [FLD_W-1:0] fld_q;
	logic [63:0]      val_q;
	logic             out_valid_q;
	enc_t             out_q;

	logic [LEN_W-1:0] len_d;
	logic [63:0]      fld_val;
	logic             val_last;
	logic [7:0]       byte_d;
	logic [FLD_W-1:0] fld_num;

	// Entry length: six one-byte keys plus the varint length of each value.
	always_comb begin
		len_d = LEN_W'(NUM_FIELDS)
			+ LEN_W'(varint_bytes(64'(rec.rnti)))
			+ LEN_W'(varint_bytes(rec.time_us))
			+ LEN_W'(varint_bytes(64'(rec.ta_value)))
			+ LEN_W'(varint_bytes(64'(rec.source)))
			+ LEN_W'(varint_bytes(64'(rec.attached)))
			+ LEN_W'(varint_bytes(64'(rec.ue_idx)));
	end

	// Value of the current field, zero extended.
	always_comb begin
		unique case (fld_q)
			3'd0:    fld_val = 64'(rec_q.rnti);
			3'd1:    fld_val = rec_q.time_us;
			3'd2:    fld_val = 64'(rec_q.ta_value);
			3'd3:    fld_val = 64'(rec_q.source);
			3'd4:    fld_val = 64'(rec_q.attached);
			3'd5:    fld_val = 64'(rec_q.ue_idx);
			default: fld_val = 64'd0;
		endcase
	end

	assign val_last = (val_q[63:GROUP_BITS] == '0);
	assign fld_num  = fld_q + FLD_W'(1);

	// Byte selected for emission.
	always_comb begin
		unique case (cmd.sel)
			SEL_HDR: byte_d = TOP_KEY_BYTE;
			SEL_LEN: byte_d = 8'(len_q);
			SEL_KEY: byte_d = {2'b00, fld_num, WIRE_VARINT};
			SEL_VAL: byte_d = {~val_last, val_q[GROUP_BITS-1:0]};
			default: byte_d = 8'd0;
		endcase
	end

	// Record, length, field index and varint shifter.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rec_q <= rec;
			len_q <= len_d;
			fld_q <= '0;
		end else if (cmd.emit) begin
			if (cmd.sel == SEL_KEY) begin
				val_q <= fld_val;
			end else if (cmd.sel == SEL_VAL) begin
				val_q <= val_q >> GROUP_BITS;
				if (val_last) begin
					fld_q <= fld_num;
				end
			end
		end
	end

	// Output register: valid flag with reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!enc_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.out_byte  <= byte_d;
			out_q.last_byte <= (cmd.sel == SEL_VAL) && val_last && (fld_q == LAST_FIELD);
		end
	end

	assign enc_valid         = out_valid_q;
	assign enc               = out_q;
	assign status.out_free   = !out_valid_q || !enc_stall;
	assign status.val_last   = val_last;
	assign status.field_last = (fld_q == LAST_FIELD);

endmodule

### hw/rtl/record_varint_serializer_unit.sv
// ----------------------------------------------------------------------------
// Record varint serializer unit
// Encodes one timing-advance record per transaction as a protocol-buffer
// message and streams it out one byte per transaction.
// ----------------------------------------------------------------------------
// Each record becomes a key byte 0x0A, a one-byte entry length, and six
// key/varint pairs; the last byte of the record has last_byte set. Bytes leave
// through an output register at one per cycle while the output is not
// stalled. A record's encoded length is its entry length plus two, 14 to
// 28 bytes; the idle controller first takes the record, then emits its
// bytes one per cycle while the output is free. A new
// record is taken in the cycle after the previous record's final byte has
// been moved into the output register, while that byte may still be waiting.
module record_varint_serializer_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rec_valid,
	output logic          rec_stall,
	input  rvs_pkg::rec_t rec,
	output logic          enc_valid,
	input  logic          enc_stall,
	output rvs_pkg::enc_t enc
);
	import rvs_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	rvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Record storage, byte generation and output register.
	rvs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec       (rec),
		.enc_stall (enc_stall),
		.enc_valid (enc_valid),
		.enc       (enc),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record varint serializer testbench
// Sends timing-advance records into the serializer and checks every encoded
// output byte, and its last-byte flag, against typed bytes or a local varint
// encoder. A short table of boundary records runs first, then random records
// under several idling mixes, a long output hold and a full drain between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import rvs_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT  = 5000;
	localparam int unsigned TAIL_CYCLES     = 40;
	localparam int unsigned LONG_HOLD       = 300;
	localparam int unsigned ITEMS_PER_PHASE = 60;
	localparam int unsigned NUM_PHASES      = 4;
	localparam int unsigned MAX_REPORTS     = 50;
	localparam int unsigned KEY_SHIFT       = 3;

	// One row of directed stimulus. When typed_len is nonzero, the expected
	// bytes are given in typed, first byte in the top eight bits.
	typedef struct {
		rec_t         rec;
		int unsigned  typed_len;
		logic [223:0] typed;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      rec_valid;
	logic      rec_stall;
	rec_t      rec;
	logic      enc_valid;
	logic      enc_stall;
	enc_t      enc;

	enc_t        expected_bytes[$];
	stim_row_t   dir_rows[$];
	stim_row_t   cur_row;
	int unsigned mismatch_count;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	bit          hold_req;

	record_varint_serializer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec       (rec),
		.enc_valid (enc_valid),
		.enc_stall (enc_stall),
		.enc       (enc)
	);

	// Free-running 20 ns clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Appends a value as a base-128 varint, low group first.
	function automatic void put_varint(ref logic [7:0] entry_q[$], input logic [63:0] v);
		logic [63:0] rest;
		rest = v;
		while (rest >= 64'h80) begin
			entry_q.insert(entry_q.size(), {1'b1, rest[6:0]});
			rest = rest >> 7;
		end
		entry_q.insert(entry_q.size(), {1'b0, rest[6:0]});
	endfunction

	// Appends one entry field: its varint key, then its varint value.
	function automatic void put_field(ref logic [7:0] entry_q[$], input logic [63:0] num,
			input logic [63:0] v);
		put_varint(entry_q, (num << KEY_SHIFT) | 64'(WIRE_VARINT));
		put_varint(entry_q, v);
	endfunction

	// Encodes one record and queues its bytes as expected output.
	function automatic void encode_record(input rec_t r);
		logic [7:0] entry_q[$];
		enc_t       e;
		put_field(entry_q, 64'd1, 64'(r.rnti));
		put_field(entry_q, 64'd2, r.time_us);
		put_field(entry_q, 64'd3, 64'(r.ta_value));
		put_field(entry_q, 64'd4, 64'(r.source));
		put_field(entry_q, 64'd5, 64'(r.attached));
		put_field(entry_q, 64'd6, 64'(r.ue_idx));
		e.out_byte  = TOP_KEY_BYTE;
		e.last_byte = 1'b0;
		expected_bytes.insert(expected_bytes.size(), e);
		e.out_byte = {1'b0, 7'(entry_q.size())};
		expected_bytes.insert(expected_bytes.size(), e);
		foreach (entry_q[i]) begin
			e.out_byte  = entry_q[i];
			e.last_byte = (i == entry_q.size() - 1);
			expected_bytes.insert(expected_bytes.size(), e);
		end
	endfunction

	// Random value whose significant length is itself random, up to w bits,
	// so that varint lengths spread over their whole range.
	function automatic logic [63:0] rand_upto(input int unsigned w);
		logic [63:0] v;
		logic [63:0] mask;
		mask = (64'd1 << $urandom_range(w, 0)) - 64'd1;
		v    = {$urandom, $urandom};
		if ($urandom_range(3) == 0) begin
			v = mask;
		end
		return v & mask;
	endfunction

	function automatic rec_t rand_record();
		rec_t r;
		r.rnti     = 16'(rand_upto(16));
		r.time_us  = rand_upto(64);
		r.ta_value = 12'(rand_upto(12));
		r.source   = 8'(rand_upto(8));
		r.attached = 1'($urandom_range(1));
		r.ue_idx   = 10'(rand_upto(10));
		return r;
	endfunction

	function automatic rec_t make_rec(input logic [15:0] rnti, input logic [63:0] ts,
			input logic [11:0] ta, input logic [7:0] src, input logic att,
			input logic [9:0] ue);
		rec_t r;
		r.rnti     = rnti;
		r.time_us  = ts;
		r.ta_value = ta;
		r.source   = src;
		r.attached = att;
		r.ue_idx   = ue;
		return r;
	endfunction

	function automatic void add_row(input rec_t r, input int unsigned n,
			input logic [223:0] bytes);
		stim_row_t row;
		row.rec       = r;
		row.typed_len = n;
		row.typed     = bytes;
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("tb_top: mismatch at %0t ns: %s", $time, msg);
		end
	endtask

	// Offers one record, after a random idle gap, and holds it until taken.
	// Called and returns at a falling edge.
	task automatic send_record(input stim_row_t row);
		while ($urandom_range(99) < send_idle_pct) begin
			rec_valid <= 1'b0;
			rec       <= rand_record();
			@(negedge clk);
		end
		rec_valid <= 1'b1;
		rec       <= row.rec;
		cur_row    = row;
		do @(posedge clk); while (rec_stall);
		@(negedge clk);
	endtask

	// Output side: random stalls at the current rate, or one long hold when
	// asked, counted here.
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		enc_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				enc_stall <= 1'b1;
			end else begin
				enc_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Checks each output transaction against the oldest expected byte and
	// queues the encoding of each accepted record.
	always @(posedge clk) begin : monitor
		enc_t want;
		enc_t e;
		if (arst_n) begin
			if (enc_valid && !enc_stall) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("byte %02h with nothing expected",
						enc.out_byte));
				end else begin
					want = expected_bytes[0];
					expected_bytes.delete(0);
					if (enc.out_byte !== want.out_byte) begin
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							enc.out_byte, want.out_byte));
					end
					if (enc.last_byte !== want.last_byte) begin
						report_mismatch($sformatf("last_byte %0b, expected %0b on byte %02h",
							enc.last_byte, want.last_byte, want.out_byte));
					end
				end
			end
			if (rec_valid && !rec_stall) begin
				if (cur_row.typed_len != 0) begin
					for (int i = 0; i < int'(cur_row.typed_len); i++) begin
						e.out_byte  = cur_row.typed[223 - 8 * i -: 8];
						e.last_byte = (i == int'(cur_row.typed_len) - 1);
						expected_bytes.insert(expected_bytes.size(), e);
					end
				end else begin
					encode_record(cur_row.rec);
				end
			end
		end
	end

	// Ends the run when no transaction has moved on either side for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((rec_valid && !rec_stall) || (enc_valid && !enc_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb_top: done, errors");
		$finish;
	end

	// Main sequence: reset, directed table, random phases, drain.
	initial begin : main
		stim_row_t row;
		arst_n         = 1'b0;
		rec_valid      = 1'b0;
		rec            = '0;
		cur_row.rec    = '0;
		cur_row.typed_len = 0;
		cur_row.typed  = '0;
		mismatch_count = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// All fields zero and all fields at their maximum.
		add_row(make_rec(16'h0000, 64'h0, 12'h000, 8'h00, 1'b0, 10'h000), 14,
			{112'h0A0C_0800_1000_1800_2000_2800_3000, 112'd0});
		add_row(make_rec(16'hFFFF, '1, 12'hFFF, 8'hFF, 1'b1, 10'h3FF), 28,
			224'h0A1A_08FF_FF03_10FF_FFFF_FFFF_FFFF_FFFF_0118_FF1F_20FF_0128_0130_FF07);
		// Largest one-byte and smallest two-byte varints in every field but attached.
		add_row(make_rec(16'h007F, 64'h7F, 12'h07F, 8'h7F, 1'b0, 10'h07F), 0, '0);
		add_row(make_rec(16'h0080, 64'h80, 12'h080, 8'h80, 1'b1, 10'h080), 0, '0);
		// Three-byte boundary of the identifier.
		add_row(make_rec(16'h3FFF, 64'h3FFF, 12'h800, 8'h01, 1'b1, 10'h200), 0, '0);
		add_row(make_rec(16'h4000, 64'h4000, 12'h001, 8'hFE, 1'b0, 10'h001), 0, '0);
		// Every varint length boundary of the timestamp.
		add_row(make_rec(16'h8000, 64'h1F_FFFF, 12'h7FF, 8'h40, 1'b0, 10'h1FF), 0, '0);
		add_row(make_rec(16'h0001, 64'h20_0000, 12'h400, 8'h20, 1'b1, 10'h100), 0, '0);
		add_row(make_rec(16'h0002, 64'hFFF_FFFF, 12'h0FF, 8'h10, 1'b0, 10'h0FF), 0, '0);
		add_row(make_rec(16'h0004, 64'h1000_0000, 12'h100, 8'h08, 1'b1, 10'h002), 0, '0);
		add_row(make_rec(16'h0008, 64'h7_FFFF_FFFF, 12'h002, 8'h04, 1'b0, 10'h004), 0, '0);
		add_row(make_rec(16'h0010, 64'h8_0000_0000, 12'h004, 8'h02, 1'b1, 10'h008), 0, '0);
		add_row(make_rec(16'h0020, 64'h3FF_FFFF_FFFF, 12'h008, 8'h03, 1'b0, 10'h010), 0, '0);
		add_row(make_rec(16'h0040, 64'h400_0000_0000, 12'h010, 8'h05, 1'b1, 10'h020), 0, '0);
		add_row(make_rec(16'h0100, 64'h1_FFFF_FFFF_FFFF, 12'h020, 8'h06, 1'b0, 10'h040),
			0, '0);
		add_row(make_rec(16'h0200, 64'h2_0000_0000_0000, 12'h040, 8'h07, 1'b1, 10'h03F),
			0, '0);
		add_row(make_rec(16'h0400, 64'h00FF_FFFF_FFFF_FFFF, 12'h003, 8'h81, 1'b0, 10'h081),
			0, '0);
		add_row(make_rec(16'h0800, 64'h0100_0000_0000_0000, 12'h081, 8'hC0, 1'b1, 10'h300),
			0, '0);
		add_row(make_rec(16'h1000, 64'h7FFF_FFFF_FFFF_FFFF, 12'hF00, 8'hE0, 1'b0, 10'h3FE),
			0, '0);
		add_row(make_rec(16'h2000, 64'h8000_0000_0000_0000, 12'hFFE, 8'hF0, 1'b1, 10'h380),
			0, '0);
		// Alternating bit patterns.
		add_row(make_rec(16'hAAAA, 64'hAAAA_AAAA_AAAA_AAAA, 12'hAAA, 8'hAA, 1'b0, 10'h2AA),
			0, '0);
		add_row(make_rec(16'h5555, 64'h5555_5555_5555_5555, 12'h555, 8'h55, 1'b1, 10'h155),
			0, '0);

		foreach (dir_rows[i]) begin
			send_record(dir_rows[i]);
		end

		row.typed_len = 0;
		row.typed     = '0;
		for (int phase = 0; phase < int'(NUM_PHASES); phase++) begin
			// Idling mix of this phase.
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					hold_req       = 1'b1;
				end
				1: begin
					send_idle_pct  = 57;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 57;
				end
				default: begin
					send_idle_pct  = 19;
					recv_stall_pct = 19;
				end
			endcase
			repeat (ITEMS_PER_PHASE) begin
				row.rec = rand_record();
				send_record(row);
			end
			// Pause the sender until every expected byte has come out.
			rec_valid <= 1'b0;
			@(negedge clk);
			while (expected_bytes.size() != 0) begin
				@(negedge clk);
			end
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && expected_bytes.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/rvs_pkg.sv
hw/rtl/rvs_ctrl.sv
hw/rtl/rvs_datapath.sv
hw/rtl/record_varint_serializer_unit.sv
tb/sv/tb_top.sv
